### rtl/core/napot_rac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napot_rac_pkg
// Shared types and codes of the NAPOT region access checker.
// ----------------------------------------------------------------------------
package napot_rac_pkg;

	// Width of the entries_in_use result field.
	localparam int ENTRIES_W = 5;

	// Width of the register address on the configuration port.
	localparam int PADDR_W = 3;

	// Width of the stored permission bits (read, write, execute).
	localparam int PERM_W = 3;
	localparam int PERM_R = 0;
	localparam int PERM_W_BIT = 1;

	// Command codes of a request transaction. Code 3 is unused.
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_CHECK = 2'd2
	} cmd_t;

	// Status codes of a response transaction.
	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_FULL = 2'd1,
		STATUS_BAD  = 2'd2
	} status_t;

	// Configuration register indexes, as selected by paddr bit 2.
	typedef enum logic {
		REG_SCHED_RUNNING = 1'b0,
		REG_TASK_PRIV     = 1'b1
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FIN
	} state_t;

	// Configuration register contents.
	typedef struct packed {
		logic sched_running;
		logic task_priv;
	} cfg_t;

	// Verdict of the span unit for one table entry.
	typedef struct packed {
		logic valid;
		logic overlap;
		logic contain;
		logic perm_ok;
	} verdict_t;

endpackage

### rtl/core/napot_rac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napot_rac_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module napot_rac_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/napot_rac_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napot_rac_cfg
// APB-style configuration registers: scheduler running and task privileged.
// ----------------------------------------------------------------------------
module napot_rac_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [napot_rac_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output napot_rac_pkg::cfg_t               cfg
);

	napot_rac_pkg::cfg_t cfg_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (napot_rac_pkg::reg_idx_t'(paddr[2]))
				napot_rac_pkg::REG_SCHED_RUNNING: cfg_q.sched_running <= pwdata[0];
				napot_rac_pkg::REG_TASK_PRIV:     cfg_q.task_priv     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (napot_rac_pkg::reg_idx_t'(paddr[2]))
			napot_rac_pkg::REG_SCHED_RUNNING: prdata = {31'd0, cfg_q.sched_running};
			napot_rac_pkg::REG_TASK_PRIV:     prdata = {31'd0, cfg_q.task_priv};
			default:                          prdata = 32'd0;
		endcase
	end

endmodule

### rtl/core/napot_rac_span.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napot_rac_span
// Shared span unit: decodes one NAPOT word into its byte range and compares
// that range with the buffer under check.
// ----------------------------------------------------------------------------
module napot_rac_span (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             flush,
	input  logic [31:0]                      word,
	input  logic [napot_rac_pkg::PERM_W-1:0] perm,
	input  logic [31:0]                      start,
	input  logic [31:0]                      last,
	input  logic [1:0]                       want,
	output napot_rac_pkg::verdict_t          verdict
);

	logic [32:0]                      word_inc;
	logic [32:0]                      size_unit;
	logic [33:0]                      lo_d;
	logic [35:0]                      hi_d;
	logic                             valid_s2;
	logic [35:0]                      lo_s2;
	logic [35:0]                      hi_s2;
	logic [napot_rac_pkg::PERM_W-1:0] perm_s2;
	logic [35:0]                      s_ext;
	logic [35:0]                      e_ext;

	// The lowest clear bit of the word marks the region size in units of
	// eight bytes; clearing the trailing ones gives the base word.
	assign word_inc  = {1'b0, word} + 33'd1;
	assign size_unit = ~{1'b0, word} & word_inc;
	assign lo_d      = {word & word_inc[31:0], 2'b00};
	assign hi_d      = {2'b00, lo_d} + {size_unit, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid && !flush;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			lo_s2   <= {2'b00, lo_d};
			hi_s2   <= hi_d;
			perm_s2 <= perm;
		end
	end

	assign s_ext = {4'd0, start};
	assign e_ext = {4'd0, last};

	always_comb begin
		verdict.valid   = valid_s2;
		verdict.overlap = !((e_ext < lo_s2) || (hi_s2 <= s_ext));
		verdict.contain = (lo_s2 <= s_ext) && (e_ext < hi_s2);
		verdict.perm_ok = !(want[0] && !perm_s2[napot_rac_pkg::PERM_R])
			&& !(want[1] && !perm_s2[napot_rac_pkg::PERM_W_BIT]);
	end

endmodule

### rtl/core/napot_region_access_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napot_region_access_checker_unit
// Table of NAPOT memory regions with permission checks on buffers.
// ----------------------------------------------------------------------------
// A request transaction carries cmd, base_addr, byte_count and perm_bits and
// is taken when req_valid is high and req_stall is low. Every request yields
// exactly one response transaction (granted, status, entries_in_use), handed
// over when rsp_valid is high and rsp_stall is low.
// Clear and add pass through the execute and finish states before their
// response is registered. A check that is decided up front (scheduler
// stopped, privileged task, zero length or address wrap) takes the same path.
// A check that scans the table goes through the scan state, where the shared
// span unit looks at one stored region per cycle behind the registered RAM read.
// One request is worked on at a time: req_stall is high from acceptance
// until the response has been moved into the output register. The next
// request can be taken in the cycle in which rsp_valid rises.
// While the receiver stalls, the response stays in the output register and
// a new request is still taken; its own result waits until that register
// is free.
// Reset empties the table (the count goes to zero) and clears both
// configuration registers; the region RAM itself is not cleared.
// ----------------------------------------------------------------------------
module napot_region_access_checker_unit #(
	parameter int MAX_REGIONS      = 16,
	parameter int MIN_REGION_BYTES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request channel.
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [1:0]                          cmd,
	input  logic [31:0]                         base_addr,
	input  logic [31:0]                         byte_count,
	input  logic [2:0]                          perm_bits,
	// Response channel.
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic                                granted,
	output logic [1:0]                          status,
	output logic [napot_rac_pkg::ENTRIES_W-1:0] entries_in_use,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [napot_rac_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int AW     = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW     = $clog2(MAX_REGIONS + 1);
	localparam int PW     = napot_rac_pkg::PERM_W;
	localparam int RAM_W  = 32 + PW;

	napot_rac_pkg::state_t   state_q, state_d;
	napot_rac_pkg::cfg_t     cfg;
	napot_rac_pkg::verdict_t vd;
	napot_rac_pkg::status_t  add_status;

	// Captured request.
	logic [1:0]         cmd_q;
	logic [31:0]        base_q;
	logic [31:0]        size_q;
	logic [31:0]        size_m1_q;
	logic [PW-1:0]      perm_q;
	logic [31:0]        last_q;

	// Table and scan control.
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      rd_idx_q;
	logic               v1_q;

	// Pending result and output register.
	logic                   res_granted_q;
	napot_rac_pkg::status_t res_status_q;
	logic                   rsp_valid_q;
	logic                   granted_q;
	napot_rac_pkg::status_t status_q;
	logic [napot_rac_pkg::ENTRIES_W-1:0] entries_q;

	logic               req_accept;
	logic               rsp_free;
	logic               full;
	logic               bad;
	logic               add_ok;
	logic               fast_grant;
	logic [31:0]        last_sum;
	logic               wrap;
	logic               issue;
	logic               ram_we;
	logic [RAM_W-1:0]   ram_wdata;
	logic [RAM_W-1:0]   ram_rdata;
	logic [31:0]        new_word;
	logic               scan_deny;
	logic               scan_hit;
	logic               scan_done;
	logic               span_flush;

	assign req_stall  = (state_q != napot_rac_pkg::ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;

	assign rsp_valid      = rsp_valid_q;
	assign granted        = granted_q;
	assign status         = status_q;
	assign entries_in_use = entries_q;

	napot_rac_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Add: the full test comes before the size and alignment tests.
	assign full = (cnt_q >= CW'(MAX_REGIONS));
	assign bad  = (size_q == 32'd0) || ((size_q & size_m1_q) != 32'd0)
		|| (size_q < 32'(MIN_REGION_BYTES)) || ((base_q & size_m1_q) != 32'd0);
	assign add_ok   = !full && !bad;
	assign new_word = (base_q >> 2) | ((size_q >> 3) - 32'd1);

	always_comb begin
		if (full) begin
			add_status = napot_rac_pkg::STATUS_FULL;
		end else if (bad) begin
			add_status = napot_rac_pkg::STATUS_BAD;
		end else begin
			add_status = napot_rac_pkg::STATUS_OK;
		end
	end

	// Check: the last byte of the buffer is start + length - 1. The buffer
	// wraps when start + length reaches 2^32, which is the case exactly when
	// start is above the complement of the length.
	assign fast_grant = !cfg.sched_running || cfg.task_priv || (size_q == 32'd0);
	assign last_sum   = base_q + size_m1_q;
	assign wrap       = (base_q > ~size_q);

	assign ram_we    = (state_q == napot_rac_pkg::ST_EXEC)
		&& (cmd_q == napot_rac_pkg::CMD_ADD) && add_ok;
	assign ram_wdata = {perm_q, new_word};

	napot_rac_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_REGIONS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// The span unit sees one entry per cycle, in the cycle after its read.
	assign span_flush = scan_done || (state_q != napot_rac_pkg::ST_SCAN);

	napot_rac_span u_span (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v1_q),
		.flush    (span_flush),
		.word     (ram_rdata[31:0]),
		.perm     (ram_rdata[RAM_W-1:32]),
		.start    (base_q),
		.last     (last_q),
		.want     (perm_q[1:0]),
		.verdict  (vd)
	);

	// The first overlapping region without the needed permission denies;
	// the first region that holds the whole buffer grants. With nothing left
	// in flight and every entry read, the check denies.
	assign scan_deny = vd.valid && vd.overlap && !vd.perm_ok;
	assign scan_hit  = vd.valid && vd.contain;
	assign scan_done = (state_q == napot_rac_pkg::ST_SCAN)
		&& (scan_deny || scan_hit || (!v1_q && !vd.valid && (rd_idx_q == cnt_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= napot_rac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		unique case (state_q)
			napot_rac_pkg::ST_IDLE: begin
				if (req_accept) begin
					state_d = napot_rac_pkg::ST_EXEC;
				end
			end
			napot_rac_pkg::ST_EXEC: begin
				if ((cmd_q == napot_rac_pkg::CMD_CHECK) && !fast_grant && !wrap) begin
					state_d = napot_rac_pkg::ST_SCAN;
				end else begin
					state_d = napot_rac_pkg::ST_FIN;
				end
			end
			napot_rac_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = napot_rac_pkg::ST_FIN;
				end else begin
					issue = (rd_idx_q < cnt_q);
				end
			end
			napot_rac_pkg::ST_FIN: begin
				if (rsp_free) begin
					state_d = napot_rac_pkg::ST_IDLE;
				end
			end
			default: state_d = napot_rac_pkg::ST_IDLE;
		endcase
	end

	// Control registers: table count, scan index, read-in-flight flag and
	// response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			v1_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			v1_q <= issue;
			if (state_q == napot_rac_pkg::ST_EXEC) begin
				rd_idx_q <= '0;
				case (cmd_q)
					napot_rac_pkg::CMD_CLEAR: cnt_q <= '0;
					napot_rac_pkg::CMD_ADD: begin
						if (add_ok) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
					default: ;
				endcase
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if ((state_q == napot_rac_pkg::ST_FIN) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			cmd_q     <= cmd;
			base_q    <= base_addr;
			size_q    <= byte_count;
			size_m1_q <= byte_count - 32'd1;
			perm_q    <= perm_bits;
		end
		if (state_q == napot_rac_pkg::ST_EXEC) begin
			last_q <= last_sum;
			case (cmd_q)
				napot_rac_pkg::CMD_ADD: begin
					res_granted_q <= 1'b0;
					res_status_q  <= add_status;
				end
				napot_rac_pkg::CMD_CHECK: begin
					res_granted_q <= fast_grant;
					res_status_q  <= napot_rac_pkg::STATUS_OK;
				end
				default: begin
					res_granted_q <= 1'b0;
					res_status_q  <= napot_rac_pkg::STATUS_OK;
				end
			endcase
		end
		if (scan_done) begin
			res_granted_q <= !scan_deny && scan_hit;
		end
		if ((state_q == napot_rac_pkg::ST_FIN) && rsp_free) begin
			granted_q <= res_granted_q;
			status_q  <= res_status_q;
			entries_q <= napot_rac_pkg::ENTRIES_W'(cnt_q);
		end
	end

	// The table never holds more regions than it has room for.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_REGIONS))
		else $error("region count above table depth");

	// A new response appears only when the sequencer hands one over.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == napot_rac_pkg::ST_FIN))
		else $error("response valid without a finished command");

	// An accepted request is executed in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |=> (state_q == napot_rac_pkg::ST_EXEC))
		else $error("accepted request not executed");

	// The RAM is written only by an add that passed its tests.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((cmd_q == napot_rac_pkg::CMD_ADD) && !full))
		else $error("region write outside a valid add");

endmodule
